@@ sv/dyc_pkg.sv @@
package dyc_pkg;

  // field widths
  localparam int YEAR_W = 12;
  localparam int DOY_W  = 9;
  localparam int SEC_W  = 17;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YOUT_W = 13;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;

  // register stages ahead of the output register
  localparam int PIPE_DEPTH = 7;

  // internal widths
  localparam int JDN_W   = 22;
  localparam int CENT_W  = 6;
  localparam int ALPHA_W = 6;
  localparam int NUM_W   = 26;
  localparam int JC_W    = 14;
  localparam int T_W     = 10;
  localparam int JE_W    = 5;
  localparam int OFS_W   = 9;
  localparam int REM_W   = 12;

  // calendar constants
  localparam int JDN_BASE      = 1721424;
  localparam int GREG_YEAR     = 1583;
  localparam int GREG_JD       = 2299161;
  localparam int ALPHA_OFS     = 1867216;
  localparam int GREG_CYCLE    = 146097;
  localparam int DAYS_PER_YEAR = 365;
  localparam int JB_OFS        = 1524;
  localparam int JC_SCALE      = 20;
  localparam int JC_OFS        = 2442;
  localparam int JC_DIV        = 7305;
  localparam int YEAR_OFS      = 4715;
  localparam int MONTHS        = 12;
  localparam int CENT_DIV      = 100;
  localparam int SEC_MAX       = 86399;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;

  // reciprocal multipliers: floor(x / D) = (x * M) >> K for x < 2**N
  localparam int CT_N = YEAR_W;
  localparam int CT_K = CT_N + $clog2(CENT_DIV);
  localparam longint unsigned CT_M =
    ((64'd1 << CT_K) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV);

  localparam int AL_N = 23;
  localparam int AL_K = AL_N + $clog2(GREG_CYCLE);
  localparam longint unsigned AL_M =
    ((64'd1 << AL_K) + 64'(GREG_CYCLE) - 64'd1) / 64'(GREG_CYCLE);

  localparam int JC_N = NUM_W;
  localparam int JC_K = JC_N + $clog2(JC_DIV);
  localparam longint unsigned JC_M =
    ((64'd1 << JC_K) + 64'(JC_DIV) - 64'd1) / 64'(JC_DIV);

  localparam int HR_N = SEC_W;
  localparam int HR_K = HR_N + $clog2(SEC_PER_HOUR);
  localparam longint unsigned HR_M =
    ((64'd1 << HR_K) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR);

  localparam int MN_N = REM_W;
  localparam int MN_K = MN_N + $clog2(SEC_PER_MIN);
  localparam longint unsigned MN_M =
    ((64'd1 << MN_K) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);

  // floor(30.6001 * k): days before month index k
  function automatic logic [OFS_W-1:0] month_offs(input logic [JE_W-1:0] k);
    logic [OFS_W-1:0] v;
    unique case (k)
      5'd1:    v = 9'd30;
      5'd2:    v = 9'd61;
      5'd3:    v = 9'd91;
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      5'd16:   v = 9'd489;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // ceil(30.6001 * k): smallest day count that reaches month index k
  function automatic logic [OFS_W-1:0] month_thr(input logic [JE_W-1:0] k);
    logic [OFS_W-1:0] v;
    unique case (k)
      5'd1:    v = 9'd31;
      5'd2:    v = 9'd62;
      5'd3:    v = 9'd92;
      5'd4:    v = 9'd123;
      5'd5:    v = 9'd154;
      5'd6:    v = 9'd184;
      5'd7:    v = 9'd215;
      5'd8:    v = 9'd245;
      5'd9:    v = 9'd276;
      5'd10:   v = 9'd307;
      5'd11:   v = 9'd337;
      5'd12:   v = 9'd368;
      5'd13:   v = 9'd398;
      5'd14:   v = 9'd429;
      5'd15:   v = 9'd460;
      5'd16:   v = 9'd490;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // floor(t / 30.6001) by parallel threshold compares
  function automatic logic [JE_W-1:0] month_index(input logic [T_W-1:0] t);
    logic [JE_W-1:0] idx;
    idx = '0;
    for (int k = 1; k <= 16; k++) begin
      if (t >= T_W'(month_thr(JE_W'(k)))) idx = JE_W'(k);
    end
    return idx;
  endfunction

endpackage

@@ sv/dyc_in_if.sv @@
interface dyc_in_if;
  import dyc_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   start_year;
  logic [DOY_W-1:0]    day_in_year;
  logic [SEC_W-1:0]    second_in_day;

  modport source (output valid, output start_year, output day_in_year,
                  output second_in_day, input ready);
  modport sink (input valid, input start_year, input day_in_year,
                input second_in_day, output ready);
endinterface

@@ sv/dyc_out_if.sv @@
interface dyc_out_if;
  import dyc_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    day_of_month;
  logic [MON_W-1:0]    month_number;
  logic [YOUT_W-1:0]   year_out;
  logic [HOUR_W-1:0]   hour_of_day;
  logic [MIN_W-1:0]    minute_of_hour;

  modport source (output valid, output day_of_month, output month_number,
                  output year_out, output hour_of_day, output minute_of_hour,
                  input ready);
  modport sink (input valid, input day_of_month, input month_number,
                input year_out, input hour_of_day, input minute_of_hour,
                output ready);
endinterface

@@ sv/dyc_date_calc.sv @@
module dyc_date_calc (
  input  logic                          clk,
  input  logic [dyc_pkg::PIPE_DEPTH-1:0] stage_en,
  input  logic [dyc_pkg::YEAR_W-1:0]    start_year,
  input  logic [dyc_pkg::DOY_W-1:0]     day_in_year,
  output logic [dyc_pkg::DAY_W-1:0]     day_of_month,
  output logic [dyc_pkg::MON_W-1:0]     month_number,
  output logic [dyc_pkg::YOUT_W-1:0]    year_out
);
  import dyc_pkg::*;

  localparam int CT_PW = 2 * CT_N + 2;
  localparam int AL_PW = 2 * AL_N + 2;
  localparam int JC_PW = 2 * JC_N + 2;
  localparam int YD_W  = 23;

  // stage 1: clamp, year index, century product
  logic [YEAR_W-1:0] year_c, jy_nxt, jy_r;
  logic [DOY_W-1:0]  doy_c, doy_m1_r;
  logic              greg_r;
  logic [CT_PW-1:0]  cent_p_nxt, cent_p_r;

  assign year_c     = (start_year == '0) ? YEAR_W'(1) : start_year;
  assign doy_c      = (day_in_year == '0) ? DOY_W'(1) : day_in_year;
  assign jy_nxt     = year_c - YEAR_W'(1);
  assign cent_p_nxt = CT_PW'(jy_nxt) * CT_PW'(CT_M);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      jy_r     <= jy_nxt;
      greg_r   <= (year_c >= YEAR_W'(GREG_YEAR));
      doy_m1_r <= doy_c - DOY_W'(1);
      cent_p_r <= cent_p_nxt;
    end
  end

  // stage 2: julian day number of the requested day
  logic [CENT_W-1:0] cent;
  logic [YD_W-1:0]   yd;
  logic [JDN_W-1:0]  greg_adj, jul_nxt, jdn_r;

  assign cent     = cent_p_r[CT_K +: CENT_W];
  assign yd       = YD_W'(jy_r) * YD_W'(1461);
  assign greg_adj = greg_r ? (JDN_W'(2) + JDN_W'(cent >> 2) - JDN_W'(cent)) : '0;
  assign jul_nxt  = JDN_W'(yd >> 2) + JDN_W'(JDN_BASE) + JDN_W'(doy_m1_r) + greg_adj;

  always_ff @(posedge clk) begin
    if (stage_en[1]) jdn_r <= jul_nxt;
  end

  // stage 3: gregorian century correction product
  logic [JDN_W-1:0] jdn_ofs;
  logic [AL_N-1:0]  al_x;
  logic [AL_PW-1:0] alpha_p_nxt, alpha_p_r;
  logic [JDN_W-1:0] jdn3_r;
  logic             gj_r;

  assign jdn_ofs     = jdn_r - JDN_W'(ALPHA_OFS);
  assign al_x        = AL_N'({jdn_ofs, 2'b00} - (JDN_W + 2)'(1));
  assign alpha_p_nxt = AL_PW'(al_x) * AL_PW'(AL_M);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      alpha_p_r <= alpha_p_nxt;
      jdn3_r    <= jdn_r;
      gj_r      <= (jdn_r >= JDN_W'(GREG_JD));
    end
  end

  // stage 4: shifted day count and year estimate numerator
  logic [ALPHA_W-1:0] alpha;
  logic [JDN_W-1:0]   ja, jb_nxt, jb4_r;
  logic [NUM_W-1:0]   num_nxt, num_r;

  assign alpha   = alpha_p_r[AL_K +: ALPHA_W];
  assign ja      = jdn3_r + (gj_r ? (JDN_W'(1) + JDN_W'(alpha) - JDN_W'(alpha >> 2)) : '0);
  assign jb_nxt  = ja + JDN_W'(JB_OFS);
  assign num_nxt = NUM_W'(jb_nxt) * NUM_W'(JC_SCALE) - NUM_W'(JC_OFS);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      jb4_r <= jb_nxt;
      num_r <= num_nxt;
    end
  end

  // stage 5: year estimate product
  logic [JC_PW-1:0] jc_p_r;
  logic [JDN_W-1:0] jb5_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      jc_p_r <= JC_PW'(num_r) * JC_PW'(JC_M);
      jb5_r  <= jb4_r;
    end
  end

  // stage 6: days into the march-based year
  logic [JC_W-1:0]  jc, jc6_r;
  logic [JDN_W-1:0] jd, t_full;
  logic [T_W-1:0]   t6_r;

  assign jc     = jc_p_r[JC_K +: JC_W];
  assign jd     = JDN_W'(jc) * JDN_W'(DAYS_PER_YEAR) + JDN_W'(jc >> 2);
  assign t_full = jb5_r - jd;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      jc6_r <= jc;
      t6_r  <= t_full[T_W-1:0];
    end
  end

  // stage 7: month index
  logic [JE_W-1:0] je_r;
  logic [T_W-1:0]  t7_r;
  logic [JC_W-1:0] jc7_r;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      je_r  <= month_index(t6_r);
      t7_r  <= t6_r;
      jc7_r <= jc6_r;
    end
  end

  // final day, month and year with clamps
  logic signed [T_W:0]  dd;
  logic signed [JE_W:0] mo_raw, mo;
  logic signed [15:0]   yy_raw, yy;

  always_comb begin
    dd     = $signed({1'b0, t7_r}) - $signed({2'b00, month_offs(je_r)});
    mo_raw = $signed({1'b0, je_r}) - (JE_W + 1)'(1);
    mo     = (mo_raw > (JE_W + 1)'(MONTHS)) ? (mo_raw - (JE_W + 1)'(MONTHS)) : mo_raw;
    yy_raw = $signed({2'b00, jc7_r}) - 16'(YEAR_OFS)
             - ((mo > (JE_W + 1)'(2)) ? 16'sd1 : 16'sd0);
    yy     = (yy_raw < 16'sd1) ? 16'sd1 : yy_raw;
  end

  assign day_of_month = (dd < 0) ? '0 : dd[DAY_W-1:0];
  assign month_number = (mo < 0) ? '0 : mo[MON_W-1:0];
  assign year_out     = yy[YOUT_W-1:0];

endmodule

@@ sv/dyc_clock_split.sv @@
module dyc_clock_split (
  input  logic                          clk,
  input  logic [dyc_pkg::PIPE_DEPTH-1:0] stage_en,
  input  logic [dyc_pkg::SEC_W-1:0]     second_in_day,
  output logic [dyc_pkg::HOUR_W-1:0]    hour_of_day,
  output logic [dyc_pkg::MIN_W-1:0]     minute_of_hour
);
  import dyc_pkg::*;

  localparam int HR_PW = 2 * HR_N + 2;
  localparam int MN_PW = 2 * MN_N + 2;

  // stage 1: saturate and hour product
  logic [SEC_W-1:0] sec_c, sec1_r;
  logic [HR_PW-1:0] hp_r;

  assign sec_c = (second_in_day > SEC_W'(SEC_MAX)) ? SEC_W'(SEC_MAX) : second_in_day;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sec1_r <= sec_c;
      hp_r   <= HR_PW'(sec_c) * HR_PW'(HR_M);
    end
  end

  // stage 2: hour
  logic [HOUR_W-1:0] ho2_r;
  logic [SEC_W-1:0]  sec2_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      ho2_r  <= hp_r[HR_K +: HOUR_W];
      sec2_r <= sec1_r;
    end
  end

  // stage 3: seconds in whole hours
  logic [SEC_W-1:0]  hs_r, sec3_r;
  logic [HOUR_W-1:0] ho3_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      hs_r   <= SEC_W'(ho2_r) * SEC_W'(SEC_PER_HOUR);
      sec3_r <= sec2_r;
      ho3_r  <= ho2_r;
    end
  end

  // stage 4: remainder and minute product
  logic [SEC_W-1:0]  rem_full;
  logic [MN_N-1:0]   rem;
  logic [MN_PW-1:0]  mp_r;
  logic [HOUR_W-1:0] ho4_r;

  assign rem_full = sec3_r - hs_r;
  assign rem      = rem_full[MN_N-1:0];

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      mp_r  <= MN_PW'(rem) * MN_PW'(MN_M);
      ho4_r <= ho3_r;
    end
  end

  // stages 5 to 7: minute, then delay to line up with the date path
  logic [HOUR_W-1:0] ho5_r, ho6_r, ho7_r;
  logic [MIN_W-1:0]  mi5_r, mi6_r, mi7_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      mi5_r <= mp_r[MN_K +: MIN_W];
      ho5_r <= ho4_r;
    end
    if (stage_en[5]) begin
      mi6_r <= mi5_r;
      ho6_r <= ho5_r;
    end
    if (stage_en[6]) begin
      mi7_r <= mi6_r;
      ho7_r <= ho6_r;
    end
  end

  assign hour_of_day    = ho7_r;
  assign minute_of_hour = mi7_r;

endmodule

@@ sv/day_of_year_to_calendar_date_top.sv @@
// channel  | dir | payload                                              | handshake
// in_ch    | in  | start_year, day_in_year, second_in_day               | valid/ready
// out_ch   | out | day_of_month, month_number, year_out, hour, minute   | valid/ready
//
// one beat per cycle in and out while out_ch is not stalled; each input beat passes
// the seven register stages of the date path (three reciprocal multiplies) and then
// the output register.
// rst_n is synchronous, active low, and clears the stage valid bits and the output valid bit only.
// each stage holds while the one after it is full and stalled; empty stages fill,
// so bubbles close up and a stall drops or repeats no beat.
module day_of_year_to_calendar_date_top (
  input logic     clk,
  input logic     rst_n,
  dyc_in_if.sink    in_ch,
  dyc_out_if.source out_ch
);
  import dyc_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH:0]   stage_en;
  logic                  out_valid_r;

  logic [DAY_W-1:0]  day_nxt, day_r;
  logic [MON_W-1:0]  mon_nxt, mon_r;
  logic [YOUT_W-1:0] year_nxt, year_r;
  logic [HOUR_W-1:0] hour_nxt, hour_r;
  logic [MIN_W-1:0]  min_nxt, min_r;

  // stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    stage_en[PIPE_DEPTH] = !out_valid_r || out_ch.ready;
    for (int s = PIPE_DEPTH - 1; s >= 0; s--) begin
      stage_en[s] = !vld_r[s] || stage_en[s+1];
    end
  end

  assign in_ch.ready = stage_en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_en[0]) vld_r[0] <= in_ch.valid;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        if (stage_en[s]) vld_r[s] <= vld_r[s-1];
      end
      if (stage_en[PIPE_DEPTH]) out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // date path
  dyc_date_calc u_date (
    .clk          (clk),
    .stage_en     (stage_en[PIPE_DEPTH-1:0]),
    .start_year   (in_ch.start_year),
    .day_in_year  (in_ch.day_in_year),
    .day_of_month (day_nxt),
    .month_number (mon_nxt),
    .year_out     (year_nxt)
  );

  // time of day path
  dyc_clock_split u_clock (
    .clk            (clk),
    .stage_en       (stage_en[PIPE_DEPTH-1:0]),
    .second_in_day  (in_ch.second_in_day),
    .hour_of_day    (hour_nxt),
    .minute_of_hour (min_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (stage_en[PIPE_DEPTH] && vld_r[PIPE_DEPTH-1]) begin
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.day_of_month   = day_r;
  assign out_ch.month_number   = mon_r;
  assign out_ch.year_out       = year_r;
  assign out_ch.hour_of_day    = hour_r;
  assign out_ch.minute_of_hour = min_r;

  // an accepted input beat lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted input beat missing from first stage");

  // a full last stage moves into the output register when it is free
  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_DEPTH-1] && stage_en[PIPE_DEPTH]) |=> out_valid_r)
    else $error("last stage beat not moved to output");

  // a delivered date has a month in range and a nonzero day and year
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mon_r >= MON_W'(1) && mon_r <= MON_W'(MONTHS) &&
                     day_r >= DAY_W'(1) && year_r >= YOUT_W'(1)))
    else $error("output date out of range");

  // a delivered time of day is in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hour_r <= HOUR_W'(23) && min_r <= MIN_W'(59)))
    else $error("output time of day out of range");

endmodule
